[sv/pbpe_pkg.sv]
// Shared types, constants and helper functions of the palette pixel expander.
`default_nettype none
package pbpe_pkg;

	localparam int PALETTE_ENTRIES_DEF = 256;
	localparam int MAX_SCALE_DEF = 8;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int CHAN_W = 8;
	localparam int COLOUR_W = 3 * CHAN_W;
	localparam int WORD_W = 32;
	localparam int SCALE_W = 4;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_OUT_FORMAT       = 3'd0,
		REG_RED_MASK         = 3'd1,
		REG_GREEN_MASK       = 3'd2,
		REG_BLUE_MASK        = 3'd3,
		REG_BLUR_ENABLE      = 3'd4,
		REG_HORIZONTAL_SCALE = 3'd5
	} cfg_reg_t;

	localparam logic [WORD_W-1:0] RED_MASK_RST = 32'd63488;
	localparam logic [WORD_W-1:0] GREEN_MASK_RST = 32'd2016;
	localparam logic [WORD_W-1:0] BLUE_MASK_RST = 32'd31;
	localparam logic [SCALE_W-1:0] SCALE_RST = 4'd1;

	// (80*cur + 20*prev) / 100 equals (4*cur + prev) / 5, and
	// (90*cur + 10*prev) / 100 equals (9*cur + prev) / 10.
	localparam logic [3:0] RG_CUR_WEIGHT = 4'd4;
	localparam logic [3:0] B_CUR_WEIGHT = 4'd9;
	// Reciprocals of 5 and 10, exact for every sum that can occur.
	localparam logic [11:0] RG_RECIP = 12'd3277;
	localparam int RG_RECIP_SHIFT = 14;
	localparam logic [12:0] B_RECIP = 13'd6554;
	localparam int B_RECIP_SHIFT = 16;
	localparam logic [8:0] CHAN_MAX = 9'd255;

	typedef struct packed {
		logic       zero;
		logic [4:0] low;
		logic [3:0] shift;
	} chan_place_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} colour_t;

	function automatic chan_place_t mask_info(input logic [WORD_W-1:0] mask,
		input logic fmt16);
		chan_place_t info;
		logic [5:0] count;
		count = 6'd0;
		info.low = 5'd0;
		for (int b = 0; b < WORD_W; b++) begin
			count = count + 6'(mask[b]);
		end
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (mask[b]) begin
				info.low = 5'(b);
			end
		end
		info.zero = (mask == '0);
		if (fmt16 && count < 6'd8) begin
			info.shift = 4'(6'd8 - count);
		end else begin
			info.shift = 4'd0;
		end
		return info;
	endfunction

	function automatic logic [WORD_W-1:0] place_chan(input logic [CHAN_W-1:0] chan,
		input chan_place_t info);
		logic [WORD_W-1:0] v;
		v = WORD_W'(chan >> info.shift) << info.low;
		return info.zero ? '0 : v;
	endfunction

endpackage
`default_nettype wire

[sv/pbpe_palette_ram.sv]
// Palette colour memory with one write port and one registered read port.
`default_nettype none
module pbpe_palette_ram #(
	parameter int ENTRIES = pbpe_pkg::PALETTE_ENTRIES_DEF,
	parameter int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [AW-1:0]                 waddr,
	input  wire logic [pbpe_pkg::COLOUR_W-1:0] wdata,
	input  wire logic                          re,
	input  wire logic [AW-1:0]                 raddr,
	output logic      [pbpe_pkg::COLOUR_W-1:0] rdata
);

	logic [pbpe_pkg::COLOUR_W-1:0] mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[sv/pbpe_blend.sv]
// Horizontal blur that blends the current colour with the previous one.
`default_nettype none
module pbpe_blend (
	input  wire logic              blur_enable,
	input  wire pbpe_pkg::colour_t cur,
	input  wire pbpe_pkg::colour_t prev,
	output pbpe_pkg::colour_t      blended
);

	function automatic logic [7:0] mix_rg(input logic [7:0] c, input logic [7:0] p);
		logic [10:0] sum;
		logic [22:0] prod;
		logic [8:0] q;
		sum = 11'(c) * 11'(pbpe_pkg::RG_CUR_WEIGHT) + 11'(p);
		prod = 23'(sum) * 23'(pbpe_pkg::RG_RECIP);
		q = prod[pbpe_pkg::RG_RECIP_SHIFT +: 9];
		return (q > pbpe_pkg::CHAN_MAX) ? 8'(pbpe_pkg::CHAN_MAX) : q[7:0];
	endfunction

	function automatic logic [7:0] mix_b(input logic [7:0] c, input logic [7:0] p);
		logic [11:0] sum;
		logic [24:0] prod;
		logic [8:0] q;
		sum = 12'(c) * 12'(pbpe_pkg::B_CUR_WEIGHT) + 12'(p);
		prod = 25'(sum) * 25'(pbpe_pkg::B_RECIP);
		q = prod[pbpe_pkg::B_RECIP_SHIFT +: 9];
		return (q > pbpe_pkg::CHAN_MAX) ? 8'(pbpe_pkg::CHAN_MAX) : q[7:0];
	endfunction

	always_comb begin
		if (blur_enable) begin
			blended.red = mix_rg(cur.red, prev.red);
			blended.green = mix_rg(cur.green, prev.green);
			blended.blue = mix_b(cur.blue, prev.blue);
		end else begin
			blended = cur;
		end
	end

endmodule
`default_nettype wire

[sv/pbpe_pack.sv]
// Places the three channels into the output word according to the masks.
`default_nettype none
module pbpe_pack (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        out_format,
	input  wire logic [pbpe_pkg::WORD_W-1:0] red_mask,
	input  wire logic [pbpe_pkg::WORD_W-1:0] green_mask,
	input  wire logic [pbpe_pkg::WORD_W-1:0] blue_mask,
	input  wire pbpe_pkg::colour_t           colour,
	output logic      [pbpe_pkg::WORD_W-1:0] word
);

	pbpe_pkg::chan_place_t red_place_q, green_place_q, blue_place_q;
	logic fmt16_q;
	logic [pbpe_pkg::WORD_W-1:0] raw;

	// Mask decode is registered; the user must change masks only while idle, unchecked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_place_q <= pbpe_pkg::mask_info(pbpe_pkg::RED_MASK_RST, 1'b1);
			green_place_q <= pbpe_pkg::mask_info(pbpe_pkg::GREEN_MASK_RST, 1'b1);
			blue_place_q <= pbpe_pkg::mask_info(pbpe_pkg::BLUE_MASK_RST, 1'b1);
			fmt16_q <= 1'b1;
		end else begin
			red_place_q <= pbpe_pkg::mask_info(red_mask, !out_format);
			green_place_q <= pbpe_pkg::mask_info(green_mask, !out_format);
			blue_place_q <= pbpe_pkg::mask_info(blue_mask, !out_format);
			fmt16_q <= !out_format;
		end
	end

	always_comb begin
		raw = pbpe_pkg::place_chan(colour.red, red_place_q)
			| pbpe_pkg::place_chan(colour.green, green_place_q)
			| pbpe_pkg::place_chan(colour.blue, blue_place_q);
		word = fmt16_q ? {16'd0, raw[15:0]} : raw;
	end

endmodule
`default_nettype wire

[sv/pbpe_repeat.sv]
// Output stage that repeats each packed word for the horizontal scale.
`default_nettype none
module pbpe_repeat #(
	parameter int MAX_SCALE = pbpe_pkg::MAX_SCALE_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [pbpe_pkg::SCALE_W-1:0] horizontal_scale,
	input  wire logic                         word_valid,
	input  wire logic [pbpe_pkg::WORD_W-1:0]  word_in,
	output logic                              word_ready,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [pbpe_pkg::WORD_W-1:0]  pixel_word,
	output logic                              last_copy
);

	localparam int CW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
	localparam logic [pbpe_pkg::SCALE_W:0] MAX_N = (pbpe_pkg::SCALE_W + 1)'(MAX_SCALE);

	logic valid_q;
	logic [CW-1:0] cnt_q;
	logic [pbpe_pkg::WORD_W-1:0] word_q;
	logic [pbpe_pkg::SCALE_W:0] scale_ext, n, n_m1;

	always_comb begin
		scale_ext = {1'b0, horizontal_scale};
		if (scale_ext == '0) begin
			n = (pbpe_pkg::SCALE_W + 1)'(1);
		end else if (scale_ext > MAX_N) begin
			n = MAX_N;
		end else begin
			n = scale_ext;
		end
		n_m1 = n - (pbpe_pkg::SCALE_W + 1)'(1);
	end

	assign last_copy = (cnt_q == '0);
	assign word_ready = !valid_q || (out_ready && last_copy);
	assign out_valid = valid_q;
	assign pixel_word = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q <= '0;
		end else if (word_ready) begin
			valid_q <= word_valid;
			if (word_valid) begin
				cnt_q <= n_m1[CW-1:0];
			end
		end else if (out_ready) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (word_ready && word_valid) begin
			word_q <= word_in;
		end
	end

endmodule
`default_nettype wire

[sv/palette_blur_pixel_expander_unit.sv]
// Top level of the palette pixel expander with horizontal blur.
`default_nettype none
// A request with mode 1 writes one palette entry; a request with mode 0 is a pixel that is
// looked up, optionally blended with the previous pixel, packed by the channel masks and sent
// out horizontal_scale times, clamped to 1..MAX_SCALE, with last_copy on the final copy. Requests
// pass a palette read stage and a blend stage and are packed straight into an output register, so
// one request is taken every cycle at a scale of one while out_ready is high; at a larger scale
// the output port sets the pace, while palette writes go on at one a cycle as long as the
// pipeline has room. Results pass the palette read, blend and output registers. A pixel must only
// name a palette entry that has been written before; the palette memory is not cleared by reset.
module palette_blur_pixel_expander_unit #(
	parameter int PALETTE_ENTRIES = pbpe_pkg::PALETTE_ENTRIES_DEF,
	parameter int MAX_SCALE = pbpe_pkg::MAX_SCALE_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [pbpe_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [pbpe_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             mode,
	input  wire logic [7:0]                       index,
	input  wire logic [7:0]                       red_in,
	input  wire logic [7:0]                       green_in,
	input  wire logic [7:0]                       blue_in,
	input  wire logic                             line_start,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic      [pbpe_pkg::WORD_W-1:0]      pixel_word,
	output logic                                  last_copy
);

	localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam logic [8:0] ENTRIES_N = 9'(PALETTE_ENTRIES);

	logic out_format_q, blur_enable_q;
	logic [pbpe_pkg::WORD_W-1:0] red_mask_q, green_mask_q, blue_mask_q;
	logic [pbpe_pkg::SCALE_W-1:0] scale_q;

	logic in_accept, in_range, ram_we, ram_re;
	logic [pbpe_pkg::COLOUR_W-1:0] ram_rdata;

	logic valid_s1, line_start_s1, in_range_s1;
	logic valid_s2;
	pbpe_pkg::colour_t colour_s2;
	pbpe_pkg::colour_t prev_colour_q;
	pbpe_pkg::colour_t cur_s1, prev_s1, blended_s1;
	logic ready_s1, ready_s2, ready_s3;
	logic [pbpe_pkg::WORD_W-1:0] word_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_format_q <= 1'b0;
			red_mask_q <= pbpe_pkg::RED_MASK_RST;
			green_mask_q <= pbpe_pkg::GREEN_MASK_RST;
			blue_mask_q <= pbpe_pkg::BLUE_MASK_RST;
			blur_enable_q <= 1'b0;
			scale_q <= pbpe_pkg::SCALE_RST;
		end else if (cfg_valid) begin
			case (pbpe_pkg::cfg_reg_t'(cfg_index))
				pbpe_pkg::REG_OUT_FORMAT: out_format_q <= cfg_data[0];
				pbpe_pkg::REG_RED_MASK: red_mask_q <= cfg_data;
				pbpe_pkg::REG_GREEN_MASK: green_mask_q <= cfg_data;
				pbpe_pkg::REG_BLUE_MASK: blue_mask_q <= cfg_data;
				pbpe_pkg::REG_BLUR_ENABLE: blur_enable_q <= cfg_data[0];
				pbpe_pkg::REG_HORIZONTAL_SCALE: scale_q <= cfg_data[pbpe_pkg::SCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;
	assign in_accept = in_valid && in_ready;
	assign in_range = ({1'b0, index} < ENTRIES_N);
	assign ram_we = in_accept && mode && in_range;
	assign ram_re = in_accept && !mode;

	pbpe_palette_ram #(
		.ENTRIES(PALETTE_ENTRIES),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(index[AW-1:0]),
		.wdata({red_in, green_in, blue_in}),
		.re(ram_re),
		.raddr(index[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_accept && !mode;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			line_start_s1 <= line_start;
			in_range_s1 <= in_range;
		end
	end

	assign cur_s1 = in_range_s1 ? pbpe_pkg::colour_t'(ram_rdata) : '0;
	assign prev_s1 = line_start_s1 ? cur_s1 : prev_colour_q;

	pbpe_blend u_blend (
		.blur_enable(blur_enable_q),
		.cur(cur_s1),
		.prev(prev_s1),
		.blended(blended_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			prev_colour_q <= '0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				prev_colour_q <= cur_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			colour_s2 <= blended_s1;
		end
	end

	pbpe_pack u_pack (
		.clk(clk),
		.arst_n(arst_n),
		.out_format(out_format_q),
		.red_mask(red_mask_q),
		.green_mask(green_mask_q),
		.blue_mask(blue_mask_q),
		.colour(colour_s2),
		.word(word_s2)
	);

	pbpe_repeat #(
		.MAX_SCALE(MAX_SCALE)
	) u_repeat (
		.clk(clk),
		.arst_n(arst_n),
		.horizontal_scale(scale_q),
		.word_valid(valid_s2),
		.word_in(word_s2),
		.word_ready(ready_s3),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pixel_word(pixel_word),
		.last_copy(last_copy)
	);

endmodule
`default_nettype wire

[sv/pbpe_checker.sv]
// Port checker for the palette pixel expander and its bind to the top level.
`default_nettype none
module pbpe_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        cfg_ready,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [pbpe_pkg::WORD_W-1:0] pixel_word,
	input wire logic                        last_copy
);

	// A waiting result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before it was taken");

	// A waiting result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pixel_word) && $stable(last_copy))
		else $error("result payload changed while stalled");

	// Every copy but the last is followed at once by another copy of the same word.
	a_copy_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_copy |=> out_valid && pixel_word == $past(pixel_word))
		else $error("horizontal copy missing or altered");

	// With nothing in the output register the pipeline can always take a request.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready && cfg_ready)
		else $error("input stalled although the output stage is empty");

endmodule

bind palette_blur_pixel_expander_unit pbpe_checker u_pbpe_checker (
	.clk(clk),
	.arst_n(arst_n),
	.cfg_ready(cfg_ready),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.pixel_word(pixel_word),
	.last_copy(last_copy)
);
`default_nettype wire

[bench/testbench.sv]
// Self-checking testbench for the palette pixel expander: palette, blur, packing and scaling.
module testbench;

	localparam int CLK_PERIOD = 10;
	localparam int RESET_CYCLES = 8;
	localparam int DRAIN_CYCLES = 8;
	localparam int TIMEOUT_CYCLES = 600000;
	localparam int RANDOM_PHASES = 8;
	localparam int CALM_PHASES = 2;
	localparam int ITEMS_PER_PHASE = 55;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int PRESSURE_ITEMS = 40;

	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_PALETTE = 1'b1;
	localparam logic [pbpe_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED_LOW = 3'd6;
	localparam logic [pbpe_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED_HIGH = 3'd7;

	localparam int RG_PREV_WEIGHT = 20;
	localparam int B_PREV_WEIGHT = 10;
	localparam int BLEND_TOTAL = 100;
	localparam int CHANNEL_CEIL = 255;

	typedef enum int {CH_RED, CH_GREEN, CH_BLUE} channel_t;

	typedef struct packed {
		logic [pbpe_pkg::WORD_W-1:0] word;
		logic                        last;
	} copy_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic [pbpe_pkg::CFG_INDEX_W-1:0]  cfg_index = '0;
	logic [pbpe_pkg::CFG_DATA_W-1:0]   cfg_data = '0;
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	logic                              mode = MODE_PIXEL;
	logic [7:0]                        index = '0;
	logic [7:0]                        red_in = '0;
	logic [7:0]                        green_in = '0;
	logic [7:0]                        blue_in = '0;
	logic                              line_start = 1'b0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic [pbpe_pkg::WORD_W-1:0]       pixel_word;
	logic                              last_copy;

	// Shadow of the block's registers and state.
	logic                              wide_words = 1'b0;
	logic [pbpe_pkg::WORD_W-1:0]       mask_red = pbpe_pkg::RED_MASK_RST;
	logic [pbpe_pkg::WORD_W-1:0]       mask_green = pbpe_pkg::GREEN_MASK_RST;
	logic [pbpe_pkg::WORD_W-1:0]       mask_blue = pbpe_pkg::BLUE_MASK_RST;
	logic                              blend_on = 1'b0;
	logic [pbpe_pkg::SCALE_W-1:0]      repeat_count = pbpe_pkg::SCALE_RST;
	pbpe_pkg::colour_t                 last_colour = '0;
	pbpe_pkg::colour_t                 palette_shadow [256];
	bit                                entry_written [256];
	logic [7:0]                        written_list [$];
	copy_t                             expected_copies [$];

	bit                                allow_idle = 1'b1;
	int                                hold_request = 0;
	int                                error_count = 0;
	int                                words_checked = 0;
	int                                pixels_sent = 0;
	int                                writes_sent = 0;
	int                                settings_applied = 0;
	int                                input_stall_cycles = 0;

	palette_blur_pixel_expander_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.index      (index),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.line_start (line_start),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_word (pixel_word),
		.last_copy  (last_copy)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [7:0] blend(input logic [7:0] cur, input logic [7:0] prev,
		input int prev_weight);
		int v;
		v = (int'(cur) * (BLEND_TOTAL - prev_weight) + int'(prev) * prev_weight) / BLEND_TOTAL;
		if (v > CHANNEL_CEIL) begin
			v = CHANNEL_CEIL;
		end
		return 8'(v);
	endfunction

	function automatic logic [pbpe_pkg::WORD_W-1:0] pack_channel(input logic [7:0] chan,
		input logic [pbpe_pkg::WORD_W-1:0] field);
		int bits;
		int lowest;
		logic [63:0] wide;
		bits = 0;
		lowest = -1;
		for (int b = 0; b < pbpe_pkg::WORD_W; b++) begin
			if (field[b]) begin
				if (lowest < 0) begin
					lowest = b;
				end
				bits++;
			end
		end
		if (bits == 0) begin
			return '0;
		end
		wide = {56'd0, chan};
		if (!wide_words && bits < 8) begin
			wide = wide >> (8 - bits);
		end
		wide = wide << lowest;
		return wide[pbpe_pkg::WORD_W-1:0];
	endfunction

	task automatic predict_pixel(input logic [7:0] idx, input logic first_in_line);
		pbpe_pkg::colour_t cur;
		pbpe_pkg::colour_t prev;
		pbpe_pkg::colour_t mixed;
		logic [pbpe_pkg::WORD_W-1:0] word;
		int copies;
		copy_t entry;
		cur = palette_shadow[idx];
		prev = first_in_line ? cur : last_colour;
		last_colour = cur;
		mixed = cur;
		if (blend_on) begin
			mixed.red = blend(cur.red, prev.red, RG_PREV_WEIGHT);
			mixed.green = blend(cur.green, prev.green, RG_PREV_WEIGHT);
			mixed.blue = blend(cur.blue, prev.blue, B_PREV_WEIGHT);
		end
		word = pack_channel(mixed.red, mask_red) | pack_channel(mixed.green, mask_green)
			| pack_channel(mixed.blue, mask_blue);
		if (!wide_words) begin
			word[31:16] = '0;
		end
		copies = int'(repeat_count);
		if (copies == 0) begin
			copies = 1;
		end
		if (copies > pbpe_pkg::MAX_SCALE_DEF) begin
			copies = pbpe_pkg::MAX_SCALE_DEF;
		end
		for (int k = 0; k < copies; k++) begin
			entry.word = word;
			entry.last = (k == copies - 1);
			expected_copies.push_back(entry);
		end
	endtask

	// Each result is compared with the oldest expected copy.
	always @(posedge clk) begin : check_results
		copy_t want;
		if (arst_n && in_valid && !in_ready) begin
			input_stall_cycles++;
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_copies.size() == 0) begin
				$display("%0t: unexpected word: expected none, actual %h last %b",
					$time, pixel_word, last_copy);
				error_count++;
			end else begin
				want = expected_copies.pop_front();
				words_checked++;
				if (pixel_word !== want.word) begin
					$display("%0t: pixel_word mismatch: expected %h, actual %h",
						$time, want.word, pixel_word);
					error_count++;
				end
				if (last_copy !== want.last) begin
					$display("%0t: last_copy mismatch: expected %b, actual %b",
						$time, want.last, last_copy);
					error_count++;
				end
			end
		end
	end

	// The receiving side: random stalls, and one long hold-off when requested.
	initial begin : receiver
		int n;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				n = hold_request;
				hold_request = 0;
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
				out_ready <= 1'b1;
			end else if (allow_idle && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 19);
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_request(input logic kind, input logic [7:0] idx,
		input pbpe_pkg::colour_t colour, input logic first_in_line);
		int gap;
		in_valid <= 1'b1;
		mode <= kind;
		index <= idx;
		red_in <= colour.red;
		green_in <= colour.green;
		blue_in <= colour.blue;
		line_start <= first_in_line;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		if (kind == MODE_PALETTE) begin
			palette_shadow[idx] = colour;
			if (!entry_written[idx]) begin
				entry_written[idx] = 1'b1;
				written_list.push_back(idx);
			end
			writes_sent++;
		end else begin
			predict_pixel(idx, first_in_line);
			pixels_sent++;
		end
		if (allow_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_entry(input logic [7:0] idx, input pbpe_pkg::colour_t colour);
		send_request(MODE_PALETTE, idx, colour, 1'($urandom));
	endtask

	task automatic show_pixel(input logic [7:0] idx, input logic first_in_line);
		send_request(MODE_PIXEL, idx, pbpe_pkg::colour_t'($urandom), first_in_line);
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (expected_copies.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [pbpe_pkg::CFG_INDEX_W-1:0] reg_index,
		input logic [pbpe_pkg::CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= reg_index;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		case (reg_index)
			pbpe_pkg::REG_OUT_FORMAT: wide_words = value[0];
			pbpe_pkg::REG_RED_MASK: mask_red = value;
			pbpe_pkg::REG_GREEN_MASK: mask_green = value;
			pbpe_pkg::REG_BLUE_MASK: mask_blue = value;
			pbpe_pkg::REG_BLUR_ENABLE: blend_on = value[0];
			pbpe_pkg::REG_HORIZONTAL_SCALE: repeat_count = value[pbpe_pkg::SCALE_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Unused upper bits of the narrow registers carry random data.
	task automatic apply_setting(input logic fmt, input logic [pbpe_pkg::WORD_W-1:0] red,
		input logic [pbpe_pkg::WORD_W-1:0] green, input logic [pbpe_pkg::WORD_W-1:0] blue,
		input logic blur, input logic [pbpe_pkg::SCALE_W-1:0] scale);
		drain_pipeline();
		write_reg(pbpe_pkg::REG_OUT_FORMAT, {31'($urandom), fmt});
		write_reg(pbpe_pkg::REG_RED_MASK, red);
		write_reg(pbpe_pkg::REG_GREEN_MASK, green);
		write_reg(pbpe_pkg::REG_BLUE_MASK, blue);
		write_reg(pbpe_pkg::REG_BLUR_ENABLE, {31'($urandom), blur});
		write_reg(pbpe_pkg::REG_HORIZONTAL_SCALE, {28'($urandom), scale});
		settings_applied++;
	endtask

	function automatic logic [7:0] biased_channel();
		case ($urandom_range(0, 3))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic pbpe_pkg::colour_t random_colour();
		pbpe_pkg::colour_t c;
		c.red = biased_channel();
		c.green = biased_channel();
		c.blue = biased_channel();
		return c;
	endfunction

	function automatic logic [pbpe_pkg::WORD_W-1:0] pick_mask(input channel_t ch,
		input logic fmt);
		logic [63:0] field;
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return pbpe_pkg::WORD_W'(1) << $urandom_range(0, 31);
			3: begin
				field = ((64'd1 << $urandom_range(1, 12)) - 64'd1) << $urandom_range(0, 31);
				return field[pbpe_pkg::WORD_W-1:0];
			end
			4: return $urandom;
			default: begin
				case (ch)
					CH_RED: return fmt ? 32'h00FF0000 : pbpe_pkg::RED_MASK_RST;
					CH_GREEN: return fmt ? 32'h0000FF00 : pbpe_pkg::GREEN_MASK_RST;
					default: return fmt ? 32'h000000FF : pbpe_pkg::BLUE_MASK_RST;
				endcase
			end
		endcase
	endfunction

	task automatic test_reset_defaults();
		write_entry(8'd0, 24'h000000);
		write_entry(8'd255, 24'hFFFFFF);
		write_entry(8'hA5, 24'h807F01);
		write_entry(8'h5A, 24'h123456);
		show_pixel(8'd255, 1'b1);
		show_pixel(8'd0, 1'b0);
		show_pixel(8'hA5, 1'b0);
		show_pixel(8'h5A, 1'b1);
	endtask

	task automatic test_output_formats();
		apply_setting(1'b1, 32'h00FF0000, 32'h0000FF00, 32'h000000FF, 1'b0, 4'd1);
		show_pixel(8'd255, 1'b0);
		show_pixel(8'hA5, 1'b0);
		// A field reaching the top of the word, one running off it, and a channel with no field at all.
		apply_setting(1'b1, 32'hFF000000, 32'h80000000, 32'h00000000, 1'b0, 4'd1);
		show_pixel(8'd255, 1'b0);
		show_pixel(8'hA5, 1'b0);
		// A short word with a field wider than a channel.
		apply_setting(1'b0, 32'h0000FFF0, 32'h0000000F, 32'h00000000, 1'b0, 4'd1);
		show_pixel(8'd255, 1'b0);
		show_pixel(8'h5A, 1'b0);
	endtask

	task automatic test_blur();
		apply_setting(1'b1, 32'h00FF0000, 32'h0000FF00, 32'h000000FF, 1'b1, 4'd1);
		show_pixel(8'd255, 1'b1);
		show_pixel(8'd0, 1'b0);
		show_pixel(8'd255, 1'b0);
		show_pixel(8'h5A, 1'b1);
		show_pixel(8'hA5, 1'b0);
	endtask

	task automatic test_scaling();
		apply_setting(1'b0, pbpe_pkg::RED_MASK_RST, pbpe_pkg::GREEN_MASK_RST,
			pbpe_pkg::BLUE_MASK_RST, 1'b0, 4'd0);
		show_pixel(8'hA5, 1'b0);
		apply_setting(1'b0, pbpe_pkg::RED_MASK_RST, pbpe_pkg::GREEN_MASK_RST,
			pbpe_pkg::BLUE_MASK_RST, 1'b1, 4'd8);
		show_pixel(8'h5A, 1'b0);
		apply_setting(1'b1, 32'h00FF0000, 32'h0000FF00, 32'h000000FF, 1'b0, 4'd15);
		show_pixel(8'd255, 1'b1);
		apply_setting(1'b1, 32'h00FF0000, 32'h0000FF00, 32'h000000FF, 1'b0, 4'd3);
		show_pixel(8'd0, 1'b0);
	endtask

	task automatic test_unused_registers();
		drain_pipeline();
		write_reg(REG_UNMAPPED_LOW, $urandom);
		write_reg(REG_UNMAPPED_HIGH, $urandom);
		show_pixel(8'hA5, 1'b0);
	endtask

	// The receiver stops for a long time while requests keep coming, so the block backs up.
	task automatic test_backpressure();
		apply_setting(1'b1, 32'h00FF0000, 32'h0000FF00, 32'h000000FF, 1'b1, 4'd4);
		hold_request = HOLD_OFF_CYCLES;
		for (int i = 0; i < PRESSURE_ITEMS; i++) begin
			if (i % 5 == 4) begin
				write_entry(8'($urandom), random_colour());
			end else begin
				show_pixel(written_list[$urandom_range(0, written_list.size() - 1)], i % 8 == 0);
			end
		end
	endtask

	task automatic test_random_stream();
		int line_left;
		logic first;
		logic fmt;
		line_left = 0;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			fmt = 1'($urandom);
			apply_setting(fmt, pick_mask(CH_RED, fmt), pick_mask(CH_GREEN, fmt),
				pick_mask(CH_BLUE, fmt), 1'($urandom),
				($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
					: 4'($urandom_range(1, 3)));
			if (p >= RANDOM_PHASES - CALM_PHASES) begin
				allow_idle = 1'b0;
			end
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if ($urandom_range(0, 5) == 0) begin
					write_entry(8'($urandom), random_colour());
				end else begin
					if (line_left == 0) begin
						line_left = $urandom_range(1, 12);
						first = 1'b1;
					end else begin
						first = ($urandom_range(0, 9) == 0);
					end
					line_left--;
					show_pixel(written_list[$urandom_range(0, written_list.size() - 1)], first);
				end
			end
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_output_formats();
		test_blur();
		test_scaling();
		test_unused_registers();
		test_backpressure();
		test_random_stream();
		drain_pipeline();
		$display("Sent %0d pixels and %0d palette writes under %0d register settings.",
			pixels_sent, writes_sent, settings_applied);
		$display("Checked %0d output words; input held back for %0d cycles; %0d mismatches.",
			words_checked, input_stall_cycles, error_count);
		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("Run timed out with %0d words still expected.", expected_copies.size());
		$display("FAIL");
		$finish;
	end

endmodule
